FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the checker files of the text console engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCCW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

FILE: src/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// Types, constants, the microcode program and helper functions of the
// character-cell console engine.
// ----------------------------------------------------------------------------
package tccw_pkg;

    localparam int ROWS       = 25;
    localparam int COLUMNS    = 80;
    localparam int BLANK_CHAR = 32;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int CELL_W  = CHAR_W + ATTR_W;
    localparam int CMD_W   = 3;
    localparam int ADDR_W  = $clog2(CELL_COUNT);
    // The scroll sweep runs one row past the end of the store.
    localparam int SWEEP_W = $clog2(CELL_COUNT + COLUMNS);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_ROWS = CFG_IDX_W'(1);

    localparam logic [ATTR_W-1:0] ATTR_RESET = ATTR_W'(7);

    localparam logic [CMD_W-1:0] CMD_PUT       = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_NEWLINE   = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_BACKSPACE = CMD_W'(2);
    localparam logic [CMD_W-1:0] CMD_GOTO      = CMD_W'(3);
    localparam logic [CMD_W-1:0] CMD_CLEAR     = CMD_W'(4);
    localparam logic [CMD_W-1:0] CMD_READ      = CMD_W'(5);

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [CHAR_W-1:0] character;
        logic [ROW_W-1:0]  target_row;
        logic [COL_W-1:0]  target_column;
    } item_t;

    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_column;
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attr;
        logic              scrolled;
    } result_t;

    // Micro-operations understood by the datapath.
    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_INIT_ZERO,
        UOP_INIT_BLANK,
        UOP_FILL,
        UOP_PUT,
        UOP_NEWLINE,
        UOP_BS_MOVE,
        UOP_BS_BLANK,
        UOP_GOTO,
        UOP_READ,
        UOP_SCROLL_INIT,
        UOP_COPY,
        UOP_DONE
    } uop_t;

    // Jump conditions tested by the sequencer.
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_START,
        C_WRAP_BOTTOM,
        C_BOTTOM,
        C_BS_STOP,
        C_FILL_MORE,
        C_COPY_MORE
    } cond_t;

    // Program steps.
    typedef enum logic [3:0] {
        ST_RST_INIT,
        ST_RST_FILL,
        ST_IDLE,
        ST_PUT,
        ST_NEWLINE,
        ST_BS_CHECK,
        ST_BS_MOVE,
        ST_BS_BLANK,
        ST_GOTO,
        ST_CLR_INIT,
        ST_CLR_FILL,
        ST_READ,
        ST_SCR_INIT,
        ST_SCR_COPY,
        ST_DONE
    } step_t;

    typedef struct packed {
        uop_t  op;
        cond_t cond;
        step_t jt;
        step_t jf;
    } ucode_t;

    typedef struct packed {
        logic wrap_bottom;
        logic bottom;
        logic bs_stop;
        logic fill_more;
        logic copy_more;
    } dp_status_t;

    // The control store: one word per step, jump to jt when the condition
    // holds and to jf otherwise.
    function automatic ucode_t ucode_rom(input step_t st);
        ucode_t w;
        case (st)
            ST_RST_INIT: w = '{UOP_INIT_ZERO,   C_ALWAYS,      ST_RST_FILL, ST_RST_FILL};
            ST_RST_FILL: w = '{UOP_FILL,        C_FILL_MORE,   ST_RST_FILL, ST_IDLE};
            ST_IDLE:     w = '{UOP_NOP,         C_START,       ST_IDLE,     ST_IDLE};
            ST_PUT:      w = '{UOP_PUT,         C_WRAP_BOTTOM, ST_SCR_INIT, ST_DONE};
            ST_NEWLINE:  w = '{UOP_NEWLINE,     C_BOTTOM,      ST_SCR_INIT, ST_DONE};
            ST_BS_CHECK: w = '{UOP_NOP,         C_BS_STOP,     ST_DONE,     ST_BS_MOVE};
            ST_BS_MOVE:  w = '{UOP_BS_MOVE,     C_ALWAYS,      ST_BS_BLANK, ST_BS_BLANK};
            ST_BS_BLANK: w = '{UOP_BS_BLANK,    C_ALWAYS,      ST_DONE,     ST_DONE};
            ST_GOTO:     w = '{UOP_GOTO,        C_ALWAYS,      ST_DONE,     ST_DONE};
            ST_CLR_INIT: w = '{UOP_INIT_BLANK,  C_ALWAYS,      ST_CLR_FILL, ST_CLR_FILL};
            ST_CLR_FILL: w = '{UOP_FILL,        C_FILL_MORE,   ST_CLR_FILL, ST_DONE};
            ST_READ:     w = '{UOP_READ,        C_ALWAYS,      ST_DONE,     ST_DONE};
            ST_SCR_INIT: w = '{UOP_SCROLL_INIT, C_ALWAYS,      ST_SCR_COPY, ST_SCR_COPY};
            ST_SCR_COPY: w = '{UOP_COPY,        C_COPY_MORE,   ST_SCR_COPY, ST_DONE};
            ST_DONE:     w = '{UOP_DONE,        C_ALWAYS,      ST_IDLE,     ST_IDLE};
            default:     w = '{UOP_NOP,         C_ALWAYS,      ST_IDLE,     ST_IDLE};
        endcase
        return w;
    endfunction

    // Entry step of each command; unused codes go straight to the result.
    function automatic step_t dispatch(input logic [CMD_W-1:0] cmd);
        step_t st;
        case (cmd)
            CMD_PUT:       st = ST_PUT;
            CMD_NEWLINE:   st = ST_NEWLINE;
            CMD_BACKSPACE: st = ST_BS_CHECK;
            CMD_GOTO:      st = ST_GOTO;
            CMD_CLEAR:     st = ST_CLR_INIT;
            CMD_READ:      st = ST_READ;
            default:       st = ST_DONE;
        endcase
        return st;
    endfunction

    function automatic logic [ROW_W-1:0] clamp_row(input logic [ROW_W-1:0] r);
        return (r >= ROW_W'(ROWS)) ? ROW_W'(ROWS - 1) : r;
    endfunction

    function automatic logic [COL_W-1:0] clamp_col(input logic [COL_W-1:0] c);
        return (c >= COL_W'(COLUMNS)) ? COL_W'(COLUMNS - 1) : c;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
    endfunction

endpackage

FILE: src/text_console_cell_writer.sv
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Character-cell text console engine with a microcoded control sequencer.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Payload               Direction
//   -------   ------------------   -------------------   ---------
//   command   start / busy         item   (item_t)       in
//   result    done (one cycle)     result (result_t)     out
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data   in
//
// An item is taken when start is high while busy is low, and its result is
// shown with done for exactly one cycle. Put, newline, goto and read run
// their own step and then the done step; backspace runs a check step and,
// unless it stops there, a move and a blank step, and an unused command code
// goes straight to the done step. Clear sweeps every cell, one per cycle. A
// scroll adds an init step and then moves or zeroes one cell per cycle, from
// the first scrolling row to one row past the bottom of the store, as the
// screen store has a single write port. After reset the engine zeroes the
// whole store, one cell a cycle, and stays busy meanwhile; configuration
// writes are taken throughout. The receiver cannot stall results, so a new
// item is taken in the very cycle its predecessor's result is shown.
//
module text_console_cell_writer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  tccw_pkg::item_t                   item,
    output logic                              done,
    output tccw_pkg::result_t                 result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tccw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tccw_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tccw_pkg::*;

    logic              accept;
    uop_t              uop;
    dp_status_t        status;
    result_t           dp_result;

    // Configuration registers.
    logic [ATTR_W-1:0] attr_reg, attr_next;
    logic [ROW_W-1:0]  hdr_reg,  hdr_next;

    // Result register and its one-cycle strobe.
    logic              done_reg, done_next;
    result_t           result_reg, result_next;

    // Items are only accepted while the sequencer rests in its idle step.
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    tccw_ucode_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .command (item.command),
        .status  (status),
        .uop     (uop),
        .busy    (busy)
    );

    tccw_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .item           (item),
        .uop            (uop),
        .text_attribute (attr_reg),
        .header_rows    (hdr_reg),
        .status         (status),
        .result         (dp_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
            hdr_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            attr_reg <= attr_next;
            hdr_reg  <= hdr_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_comb
    begin
        attr_next = attr_reg;
        hdr_next  = hdr_reg;
        // Writes to indexes beyond the register list are dropped.
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TEXT_ATTR:   attr_next = cfg_data[ATTR_W-1:0];
                CFG_HEADER_ROWS: hdr_next  = cfg_data[ROW_W-1:0];
                default:
                begin
                end
            endcase
        end

        // The final step of every command captures the finished result.
        done_next   = (uop == UOP_DONE);
        result_next = (uop == UOP_DONE) ? dp_result : result_reg;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: src/tccw_screen_store.sv
// ----------------------------------------------------------------------------
// tccw_screen_store
// Screen cell memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tccw_screen_store (
    input  logic                          clk,
    input  logic                          we,
    input  logic [tccw_pkg::ADDR_W-1:0]   waddr,
    input  logic [tccw_pkg::CELL_W-1:0]   wdata,
    input  logic [tccw_pkg::ADDR_W-1:0]   raddr,
    output logic [tccw_pkg::CELL_W-1:0]   rdata
);
    import tccw_pkg::*;

    logic [CELL_W-1:0] mem [CELL_COUNT];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/tccw_ucode_seq.sv
// ----------------------------------------------------------------------------
// tccw_ucode_seq
// Microcode sequencer: step counter, control store and jump logic.
// ----------------------------------------------------------------------------
module tccw_ucode_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [tccw_pkg::CMD_W-1:0]    command,
    input  tccw_pkg::dp_status_t          status,
    output tccw_pkg::uop_t                uop,
    output logic                          busy
);
    import tccw_pkg::*;

    step_t  step_reg;
    step_t  step_next;
    ucode_t cw;
    logic   taken;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_RST_INIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_comb
    begin
        cw = ucode_rom(step_reg);
        case (cw.cond)
            C_ALWAYS:      taken = 1'b1;
            C_START:       taken = accept;
            C_WRAP_BOTTOM: taken = status.wrap_bottom;
            C_BOTTOM:      taken = status.bottom;
            C_BS_STOP:     taken = status.bs_stop;
            C_FILL_MORE:   taken = status.fill_more;
            C_COPY_MORE:   taken = status.copy_more;
            default:       taken = 1'b0;
        endcase
        if (cw.cond == C_START)
        begin
            step_next = taken ? dispatch(command) : step_reg;
        end
        else
        begin
            step_next = taken ? cw.jt : cw.jf;
        end
    end

    assign uop  = cw.op;
    assign busy = (step_reg != ST_IDLE);

endmodule

FILE: src/tccw_datapath.sv
// ----------------------------------------------------------------------------
// tccw_datapath
// Cursor, sweep counter and screen store, driven one micro-operation a cycle.
// ----------------------------------------------------------------------------
module tccw_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  tccw_pkg::item_t               item,
    input  tccw_pkg::uop_t                uop,
    input  logic [tccw_pkg::ATTR_W-1:0]   text_attribute,
    input  logic [tccw_pkg::ROW_W-1:0]    header_rows,
    output tccw_pkg::dp_status_t          status,
    output tccw_pkg::result_t             result
);
    import tccw_pkg::*;

    logic [ROW_W-1:0]   row_reg,   row_next;
    logic [COL_W-1:0]   col_reg,   col_next;
    logic [SWEEP_W-1:0] sweep_reg, sweep_next;
    logic [CELL_W-1:0]  fill_reg,  fill_next;
    logic               scrolled_reg, scrolled_next;
    item_t              item_reg;

    // A copy reads one cell and writes it a row higher in the next cycle.
    logic               pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0]  pend_addr_reg,  pend_addr_next;
    logic               pend_zero_reg,  pend_zero_next;

    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [CELL_W-1:0]  wdata;
    logic [ADDR_W-1:0]  raddr;
    logic [CELL_W-1:0]  rdata;

    logic               at_last_col;
    logic               at_last_row;
    logic               past_store;
    logic [SWEEP_W-1:0] scroll_start;

    tccw_screen_store u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg        <= '0;
            col_reg        <= '0;
            sweep_reg      <= '0;
            scrolled_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg        <= row_next;
            col_reg        <= col_next;
            sweep_reg      <= sweep_next;
            scrolled_reg   <= scrolled_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_reg      <= fill_next;
        pend_addr_reg <= pend_addr_next;
        pend_zero_reg <= pend_zero_next;
        if (accept)
        begin
            item_reg <= item;
        end
    end

    always_comb
    begin
        at_last_col = (col_reg == COL_W'(COLUMNS - 1));
        at_last_row = (row_reg == ROW_W'(ROWS - 1));
        past_store  = (sweep_reg >= SWEEP_W'(CELL_COUNT));
        if (SWEEP_W'(header_rows) >= SWEEP_W'(ROWS - 1))
        begin
            scroll_start = SWEEP_W'(CELL_COUNT);
        end
        else
        begin
            scroll_start = (SWEEP_W'(header_rows) + SWEEP_W'(1)) * SWEEP_W'(COLUMNS);
        end

        status.wrap_bottom = at_last_col && at_last_row;
        status.bottom      = at_last_row;
        status.bs_stop     = (col_reg == '0) &&
                             ((row_reg == header_rows) || (row_reg == '0));
        status.fill_more   = (sweep_reg != SWEEP_W'(CELL_COUNT - 1));
        status.copy_more   = (sweep_reg != SWEEP_W'(CELL_COUNT + COLUMNS - 1));

        row_next        = row_reg;
        col_next        = col_reg;
        sweep_next      = sweep_reg;
        fill_next       = fill_reg;
        scrolled_next   = accept ? 1'b0 : scrolled_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        pend_zero_next  = pend_zero_reg;
        we              = 1'b0;
        waddr           = cell_addr(row_reg, col_reg);
        wdata           = {text_attribute, CHAR_W'(BLANK_CHAR)};
        raddr           = '0;

        case (uop)
            UOP_INIT_ZERO:
            begin
                sweep_next = '0;
                fill_next  = '0;
            end
            UOP_INIT_BLANK:
            begin
                sweep_next = '0;
                fill_next  = {text_attribute, CHAR_W'(BLANK_CHAR)};
            end
            UOP_FILL:
            begin
                we         = 1'b1;
                waddr      = sweep_reg[ADDR_W-1:0];
                wdata      = fill_reg;
                sweep_next = sweep_reg + SWEEP_W'(1);
            end
            UOP_PUT:
            begin
                we    = 1'b1;
                wdata = {text_attribute, item_reg.character};
                if (at_last_col)
                begin
                    col_next = '0;
                    row_next = at_last_row ? row_reg : row_reg + ROW_W'(1);
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
            UOP_NEWLINE:
            begin
                col_next = '0;
                row_next = at_last_row ? row_reg : row_reg + ROW_W'(1);
            end
            UOP_BS_MOVE:
            begin
                if (col_reg == '0)
                begin
                    row_next = row_reg - ROW_W'(1);
                    col_next = COL_W'(COLUMNS - 1);
                end
                else
                begin
                    col_next = col_reg - COL_W'(1);
                end
            end
            UOP_BS_BLANK:
            begin
                we = 1'b1;
            end
            UOP_GOTO:
            begin
                row_next = clamp_row(item_reg.target_row);
                col_next = clamp_col(item_reg.target_column);
            end
            UOP_READ:
            begin
                raddr = cell_addr(clamp_row(item_reg.target_row),
                                  clamp_col(item_reg.target_column));
            end
            UOP_SCROLL_INIT:
            begin
                sweep_next    = scroll_start;
                scrolled_next = 1'b1;
            end
            UOP_COPY:
            begin
                raddr           = past_store ? '0 : sweep_reg[ADDR_W-1:0];
                pend_valid_next = 1'b1;
                pend_addr_next  = ADDR_W'(sweep_reg - SWEEP_W'(COLUMNS));
                pend_zero_next  = past_store;
                sweep_next      = sweep_reg + SWEEP_W'(1);
            end
            default:
            begin
            end
        endcase

        // The delayed half of a copy; the program never writes in that cycle.
        if (pend_valid_reg)
        begin
            we    = 1'b1;
            waddr = pend_addr_reg;
            wdata = pend_zero_reg ? '0 : rdata;
        end

        result.cursor_row    = row_reg;
        result.cursor_column = col_reg;
        result.scrolled      = scrolled_reg;
        if (item_reg.command == CMD_READ)
        begin
            result.cell_char = rdata[CHAR_W-1:0];
            result.cell_attr = rdata[CELL_W-1:CHAR_W];
        end
        else
        begin
            result.cell_char = '0;
            result.cell_attr = '0;
        end
    end

endmodule

FILE: src/tccw_checker.sv
// ----------------------------------------------------------------------------
// tccw_checker
// Port-level checks of the console engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tccw_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              done,
    input  tccw_pkg::result_t                 result
);
    import tccw_pkg::*;

    logic accepted;
    logic cursor_on_screen;
    logic on_bottom_row;

    assign accepted         = start && !busy;
    assign cursor_on_screen = (result.cursor_row < ROW_W'(ROWS)) &&
                              (result.cursor_column < COL_W'(COLUMNS));
    assign on_bottom_row    = (result.cursor_row == ROW_W'(ROWS - 1));

    // A taken item keeps the engine busy in the following cycle.
    `TCCW_ASSERT_NXT(a_busy_after_accept, clk, rst_n, accepted, busy)

    // The idle step always lies between two results, so they never come back to back.
    `TCCW_ASSERT_NXT(a_done_single, clk, rst_n, done, !done)

    // A result is shown only once the engine has returned to idle.
    `TCCW_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy)

    // The reported cursor always lies on the screen.
    `TCCW_ASSERT_IMP(a_cursor_range, clk, rst_n, done, cursor_on_screen)

    // A scroll always leaves the cursor on the bottom row.
    `TCCW_ASSERT_IMP(a_scroll_bottom, clk, rst_n, done && result.scrolled, on_bottom_row)

endmodule

bind text_console_cell_writer tccw_checker u_tccw_checker (.*);

FILE: tb/text_console_cell_writer_tb.sv
// ----------------------------------------------------------------------------
// text_console_cell_writer_tb
// Self-checking testbench for the character-cell console engine. A shadow
// screen store and cursor predict the result of every accepted item; each
// result strobe is checked field by field against the oldest prediction.
// A short directed sequence covers the edge cases, then six random phases
// run under different attribute and header settings and sender idling.
// ----------------------------------------------------------------------------
module text_console_cell_writer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tccw_pkg::*;

    // The two command codes the engine does not use.
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = CMD_W'(6);
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = CMD_W'(7);

    localparam int ITEMS_PER_SETTING = 167;
    localparam int SETTLE_CYCLES     = 64;

    // Shadow of the console: screen store, cursor and both registers. Each
    // accepted item is applied here and its expected result queued; results
    // from the engine are checked in order against that queue.
    class console_scoreboard;
        logic [CELL_W-1:0] screen [CELL_COUNT];
        logic [ROW_W-1:0]  cur_row;
        logic [COL_W-1:0]  cur_col;
        logic [ATTR_W-1:0] attr;
        logic [ROW_W-1:0]  scroll_top;
        result_t           expected_q [$];
        int unsigned       mismatches;
        int unsigned       checked;
        int unsigned       scrolls;
        int unsigned       per_command [8];

        function new();
            foreach (screen[i])
                screen[i] = '0;
            cur_row    = '0;
            cur_col    = '0;
            attr       = ATTR_RESET;
            scroll_top = '0;
            mismatches = 0;
            checked    = 0;
            scrolls    = 0;
            foreach (per_command[i])
                per_command[i] = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] data);
            if (index == CFG_TEXT_ATTR)
                attr = data[ATTR_W-1:0];
            else if (index == CFG_HEADER_ROWS)
                scroll_top = data[ROW_W-1:0];
        endfunction

        // Wraps the column, and scrolls when the cursor has left the bottom
        // row. Rows below the header move up one and the bottom row is
        // zeroed; with a header of ROWS-1 or more only the zeroing happens.
        function bit settle_cursor(inout int row, inout int col);
            if (col >= COLUMNS)
            begin
                col = 0;
                row++;
            end
            if (row < ROWS)
                return 1'b0;
            for (int r = int'(scroll_top) + 1; r < ROWS; r++)
                for (int c = 0; c < COLUMNS; c++)
                    screen[(r - 1) * COLUMNS + c] = screen[r * COLUMNS + c];
            for (int c = 0; c < COLUMNS; c++)
                screen[(ROWS - 1) * COLUMNS + c] = '0;
            row = ROWS - 1;
            scrolls++;
            return 1'b1;
        endfunction

        function void note_command(item_t cmd_item);
            result_t           want;
            int                row;
            int                col;
            int                pick_row;
            int                pick_col;
            logic [CELL_W-1:0] blank;
            logic [CELL_W-1:0] word;

            want  = '0;
            row   = cur_row;
            col   = cur_col;
            blank = {attr, CHAR_W'(BLANK_CHAR)};
            pick_row = (cmd_item.target_row >= ROWS) ? ROWS - 1 : cmd_item.target_row;
            pick_col = (cmd_item.target_column >= COLUMNS) ? COLUMNS - 1
                                                           : cmd_item.target_column;
            per_command[cmd_item.command]++;

            case (cmd_item.command)
                CMD_PUT:
                begin
                    // The character lands at the cursor before it advances.
                    screen[row * COLUMNS + col] = {attr, cmd_item.character};
                    col++;
                    want.scrolled = settle_cursor(row, col);
                end
                CMD_NEWLINE:
                begin
                    row++;
                    col = 0;
                    want.scrolled = settle_cursor(row, col);
                end
                CMD_BACKSPACE:
                begin
                    if (col != 0)
                    begin
                        col--;
                        screen[row * COLUMNS + col] = blank;
                    end
                    else if (row != int'(scroll_top) && row != 0)
                    begin
                        // Column zero steps back to the end of the row above.
                        row--;
                        col = COLUMNS - 1;
                        screen[row * COLUMNS + col] = blank;
                    end
                end
                CMD_GOTO:
                begin
                    row = pick_row;
                    col = pick_col;
                end
                CMD_CLEAR:
                begin
                    foreach (screen[i])
                        screen[i] = blank;
                end
                CMD_READ:
                begin
                    word = screen[pick_row * COLUMNS + pick_col];
                    want.cell_char = word[CHAR_W-1:0];
                    want.cell_attr = word[CELL_W-1:CHAR_W];
                end
                default: ;
            endcase

            cur_row = ROW_W'(row);
            cur_col = COL_W'(col);
            want.cursor_row    = cur_row;
            want.cursor_column = cur_col;
            expected_q.push_back(want);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                $error("result strobe with no item outstanding: %p", got);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            compare_field("cursor_row", want.cursor_row, got.cursor_row);
            compare_field("cursor_column", want.cursor_column, got.cursor_column);
            compare_field("cell_char", want.cell_char, got.cell_char);
            compare_field("cell_attr", want.cell_attr, got.cell_attr);
            compare_field("scrolled", want.scrolled, got.scrolled);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    item_t                 item;
    logic                  done;
    result_t               result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    console_scoreboard board;
    int unsigned       settings_used;

    text_console_cell_writer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop. The slowest correct run (every item a full scroll or clear
    // plus the longest sender gaps) stays well inside this.
    initial
    begin
        #30ms;
        $display("text_console_cell_writer_tb failed");
        $finish;
    end

    // The receiver cannot stall, so every strobe is an accepted result.
    // Sampling at the edge sees the values of the cycle that edge ends.
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result(result);
    end

    function automatic item_t make_item(logic [CMD_W-1:0] command,
                                        logic [CHAR_W-1:0] ch,
                                        logic [ROW_W-1:0] row,
                                        logic [COL_W-1:0] col);
        item_t cmd_item;
        cmd_item.command       = command;
        cmd_item.character     = ch;
        cmd_item.target_row    = row;
        cmd_item.target_column = col;
        return cmd_item;
    endfunction

    // Mostly character writes with newlines and backspaces mixed in, so the
    // cursor wanders over whole rows. Goto targets favour the bottom row and
    // the first and last columns, where wraps and scrolls happen; half the
    // reads look near the cursor, where recent writes and scrolls landed.
    function automatic item_t random_command();
        item_t       cmd_item;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        cmd_item.character     = CHAR_W'($urandom_range(0, 255));
        cmd_item.target_row    = ROW_W'($urandom_range(0, 31));
        cmd_item.target_column = COL_W'($urandom_range(0, 127));
        if (pick < 40)
        begin
            cmd_item.command = CMD_PUT;
        end
        else if (pick < 52)
        begin
            cmd_item.command = CMD_NEWLINE;
        end
        else if (pick < 68)
        begin
            cmd_item.command = CMD_BACKSPACE;
        end
        else if (pick < 82)
        begin
            cmd_item.command = CMD_GOTO;
            if ($urandom_range(0, 5) != 0)
            begin
                cmd_item.target_row    = ROW_W'($urandom_range(0, ROWS - 1));
                cmd_item.target_column = COL_W'($urandom_range(0, COLUMNS - 1));
                case ($urandom_range(0, 3))
                    0: cmd_item.target_row = ROW_W'(ROWS - 1);
                    1: cmd_item.target_column = '0;
                    2: cmd_item.target_column = COL_W'(COLUMNS - 1);
                    default: ;
                endcase
            end
        end
        else if (pick < 94)
        begin
            cmd_item.command = CMD_READ;
            if ($urandom_range(0, 1) == 1)
            begin
                cmd_item.target_row = board.cur_row;
                if (board.cur_row != 0 && $urandom_range(0, 1) == 1)
                    cmd_item.target_row = board.cur_row - 1'b1;
                cmd_item.target_column = COL_W'($urandom_range(0, COLUMNS - 1));
            end
        end
        else if (pick < 96)
        begin
            cmd_item.command = CMD_CLEAR;
        end
        else
        begin
            cmd_item.command = ($urandom_range(0, 1) == 1) ? CMD_SPARE_6 : CMD_SPARE_7;
        end
        return cmd_item;
    endfunction

    // Presents an item and holds it until the engine takes it. Start is left
    // high so that a following item can go out back to back.
    task automatic send_command(input item_t cmd_item);
        start <= 1'b1;
        item  <= cmd_item;
        do
            @(posedge clk);
        while (busy);
        board.note_command(cmd_item);
    endtask

    // Idles the sender for a run of cycles, each cycle idle with the given
    // percentage.
    task automatic sender_gap(input int unsigned idle_pct);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct);
        end
    endtask

    // Holds the sender off until every outstanding result has come back,
    // which also leaves the engine idle for register writes.
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    // Writes both registers back to back, keeping valid high between them.
    task automatic program_registers(input logic [CFG_DATA_W-1:0] attr_value,
                                     input logic [CFG_DATA_W-1:0] rows_value);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_TEXT_ATTR;
        cfg_data  <= attr_value;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.write_register(CFG_TEXT_ATTR, attr_value);
        cfg_index <= CFG_HEADER_ROWS;
        cfg_data  <= rows_value;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.write_register(CFG_HEADER_ROWS, rows_value);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] attr_plan [6];
        logic [CFG_DATA_W-1:0] rows_plan [6];
        int unsigned           idle_pct;

        board         = new();
        settings_used = 0;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        item      <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_TEXT_ATTR;
        cfg_data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, first with the reset values of both registers.
        // The engine zeroes the whole store after reset, so the first item
        // simply waits for busy to fall.
        send_command(make_item(CMD_READ, 8'h00, 5'd0, 7'd0));
        send_command(make_item(CMD_PUT, 8'h41, 5'd0, 7'd0));
        send_command(make_item(CMD_PUT, 8'hFF, 5'd31, 7'd127));
        send_command(make_item(CMD_PUT, 8'h00, 5'd0, 7'd0));
        send_command(make_item(CMD_BACKSPACE, 8'h00, 5'd0, 7'd0));
        send_command(make_item(CMD_READ, 8'h00, 5'd0, 7'd1));
        // An out-of-range goto saturates to the bottom-right corner, and a
        // character there wraps and scrolls the whole screen.
        send_command(make_item(CMD_GOTO, 8'h00, 5'd31, 7'd127));
        send_command(make_item(CMD_PUT, 8'h5A, 5'd0, 7'd0));
        send_command(make_item(CMD_READ, 8'h00, 5'd23, 7'd79));
        send_command(make_item(CMD_NEWLINE, 8'h00, 5'd0, 7'd0));
        // Backspace at the very top does nothing; elsewhere at column zero
        // it goes to the end of the row above.
        send_command(make_item(CMD_GOTO, 8'h00, 5'd0, 7'd0));
        send_command(make_item(CMD_BACKSPACE, 8'h00, 5'd0, 7'd0));
        send_command(make_item(CMD_GOTO, 8'h00, 5'd5, 7'd0));
        send_command(make_item(CMD_BACKSPACE, 8'h00, 5'd0, 7'd0));
        send_command(make_item(CMD_READ, 8'h00, 5'd31, 7'd127));
        send_command(make_item(CMD_SPARE_6, 8'hAA, 5'd10, 7'd10));
        send_command(make_item(CMD_SPARE_7, 8'h55, 5'd21, 7'd85));
        // Wrap at the last column of a row that is not the bottom.
        send_command(make_item(CMD_GOTO, 8'h00, 5'd3, 7'd79));
        send_command(make_item(CMD_PUT, 8'h80, 5'd0, 7'd0));
        send_command(make_item(CMD_CLEAR, 8'h00, 5'd0, 7'd0));
        send_command(make_item(CMD_READ, 8'h00, 5'd12, 7'd40));

        // With a header covering every row but the last, a scroll only
        // zeroes the bottom row, and backspace stops at its first column.
        wait_drained();
        program_registers(8'hC3, CFG_DATA_W'(ROWS - 1));
        send_command(make_item(CMD_GOTO, 8'h00, 5'd24, 7'd5));
        send_command(make_item(CMD_NEWLINE, 8'h00, 5'd0, 7'd0));
        send_command(make_item(CMD_READ, 8'h00, 5'd24, 7'd5));
        send_command(make_item(CMD_BACKSPACE, 8'h00, 5'd0, 7'd0));

        // Random part: six register settings, two for each idling pattern.
        // The fifth setting is drawn at random.
        attr_plan = '{8'h00, 8'hFF, 8'h1F, 8'hA5,
                      CFG_DATA_W'($urandom_range(0, 255)), 8'h70};
        rows_plan = '{8'd0, 8'd24, 8'd3, 8'd23,
                      CFG_DATA_W'($urandom_range(0, ROWS - 1)), 8'd12};
        for (int phase = 0; phase < 6; phase++)
        begin
            wait_drained();
            program_registers(attr_plan[phase], rows_plan[phase]);
            idle_pct = (phase < 2) ? 13 : (phase < 4) ? 81 : 0;
            repeat (ITEMS_PER_SETTING)
            begin
                sender_gap(idle_pct);
                send_command(random_command());
                // Now and then let the engine run completely dry.
                if ($urandom_range(0, 59) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d put, %0d newline, %0d backspace, %0d goto, %0d clear,",
                 board.per_command[CMD_PUT], board.per_command[CMD_NEWLINE],
                 board.per_command[CMD_BACKSPACE], board.per_command[CMD_GOTO],
                 board.per_command[CMD_CLEAR]);
        $display("%0d read and %0d unused-code items; %0d results checked, %0d scrolls, %0d settings.",
                 board.per_command[CMD_READ],
                 board.per_command[CMD_SPARE_6] + board.per_command[CMD_SPARE_7],
                 board.checked, board.scrolls, settings_used + 1);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("text_console_cell_writer_tb passed");
        else
            $display("text_console_cell_writer_tb failed");
        $finish;
    end

endmodule
